### design/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg: shared types and constants of the free page stack allocator
// Holds status codes, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fpsa_pkg;

   localparam int PAGE_BITS_DEF   = 12;
   localparam int STACK_DEPTH_DEF = 32768;
   localparam int ADDR_BITS_DEF   = 32;

   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;

   localparam logic [DATA_W-1:0] KERNEL_END_RESET = 32'h8000_0000;
   localparam logic [DATA_W-1:0] PHYS_TOP_RESET   = 32'h8800_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_END = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHYS_TOP   = 8'd1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   typedef struct packed {
      logic load_req;
      logic push;
      logic pop_read;
      logic load_rsp;
      logic rsp_from_ram;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_addr;
      logic full;
      logic empty;
      logic slot_free;
   } dp_stat_type;

endpackage

### design/fpsa_ram.sv
// ----------------------------------------------------------------------------
// fpsa_ram: generic single-clock RAM
// One write port and one read port with registered read data; the read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
module fpsa_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fpsa_ctrl.sv
// ----------------------------------------------------------------------------
// fpsa_ctrl: request sequencer
// Takes one request at a time, steers the datapath through check, push or
// stack read, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fpsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fpsa_pkg::dp_stat_type stat,
   output fpsa_pkg::dp_cmd_type  cmd
);

   fpsa_pkg::state_type state_ff;
   fpsa_pkg::state_type state_in;
   logic                req_fire;

   assign req_fire = req_tvalid && (state_ff == fpsa_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = fpsa_pkg::ST_EXEC;
            end
         end
         fpsa_pkg::ST_EXEC: begin
            if (stat.is_free || stat.empty) begin
               if (stat.slot_free) begin
                  state_in = fpsa_pkg::ST_IDLE;
               end
            end else begin
               state_in = fpsa_pkg::ST_READ;
            end
         end
         fpsa_pkg::ST_READ: begin
            if (stat.slot_free) begin
               state_in = fpsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fpsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         fpsa_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         fpsa_pkg::ST_EXEC: begin
            // commit the push only together with its result beat
            cmd.push     = stat.is_free && !stat.bad_addr && !stat.full && stat.slot_free;
            cmd.pop_read = !stat.is_free && !stat.empty;
            cmd.load_rsp = (stat.is_free || stat.empty) && stat.slot_free;
         end
         fpsa_pkg::ST_READ: begin
            cmd.load_rsp     = stat.slot_free;
            cmd.rsp_from_ram = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/fpsa_datapath.sv
// ----------------------------------------------------------------------------
// fpsa_datapath: address checks, stack pointer, page store and output register
// Holds the configuration registers, the latched request, the free page
// count and the result beat waiting on the response channel.
// ----------------------------------------------------------------------------
module fpsa_datapath #(
   parameter int PAGE_BITS   = fpsa_pkg::PAGE_BITS_DEF,
   parameter int STACK_DEPTH = fpsa_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_BITS   = fpsa_pkg::ADDR_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_opcode,
   input  logic [fpsa_pkg::DATA_W-1:0]         req_addr,
   input  logic                                csr_valid,
   input  logic [fpsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fpsa_pkg::DATA_W-1:0]         csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fpsa_pkg::DATA_W-1:0]         rsp_addr,
   output logic [fpsa_pkg::STATUS_W-1:0]       rsp_status,
   input  fpsa_pkg::dp_cmd_type                cmd,
   output fpsa_pkg::dp_stat_type               stat
);

   localparam int PN_W  = ADDR_BITS - PAGE_BITS;
   localparam int EXT_W = (PN_W > fpsa_pkg::DATA_W) ? PN_W : fpsa_pkg::DATA_W;
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic                        op_ff;
   logic [fpsa_pkg::DATA_W-1:0] addr_ff;
   logic [fpsa_pkg::DATA_W-1:0] kernel_end_ff;
   logic [fpsa_pkg::DATA_W-1:0] phys_top_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [fpsa_pkg::DATA_W-1:0] rsp_addr_ff;
   logic [fpsa_pkg::DATA_W-1:0] rsp_addr_in;
   fpsa_pkg::status_type        rsp_status_ff;
   fpsa_pkg::status_type        rsp_status_in;

   logic [CNT_W-1:0]            count_dec;
   logic [fpsa_pkg::DATA_W-1:0] page_shifted;
   logic [EXT_W-1:0]            pn_ext;
   logic [EXT_W-1:0]            rd_ext;
   logic [PN_W-1:0]             rd_data;
   logic [fpsa_pkg::DATA_W-1:0] ram_page_addr;
   fpsa_pkg::status_type        exec_status;

   // request latch and configuration registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_opcode;
         addr_ff <= req_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= fpsa_pkg::KERNEL_END_RESET;
         phys_top_ff   <= fpsa_pkg::PHYS_TOP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fpsa_pkg::CSR_KERNEL_END: kernel_end_ff <= csr_data;
            fpsa_pkg::CSR_PHYS_TOP:   phys_top_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // checks on the latched request
   assign stat.is_free   = (op_ff == fpsa_pkg::OP_FREE);
   assign stat.bad_addr  = (addr_ff[PAGE_BITS-1:0] != '0) || (addr_ff < kernel_end_ff) ||
                           (addr_ff >= phys_top_ff);
   assign stat.full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (!stat.is_free) begin
         exec_status = fpsa_pkg::STATUS_EMPTY;
      end else if (stat.bad_addr) begin
         exec_status = fpsa_pkg::STATUS_BAD_ADDR;
      end else if (stat.full) begin
         exec_status = fpsa_pkg::STATUS_FULL;
      end else begin
         exec_status = fpsa_pkg::STATUS_OK;
      end
   end

   // stack pointer
   assign count_dec = count_ff - CNT_W'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop_read) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // page number in and out of the store
   assign page_shifted  = addr_ff >> PAGE_BITS;
   assign pn_ext        = EXT_W'(page_shifted);
   assign rd_ext        = EXT_W'(rd_data);
   assign ram_page_addr = rd_ext[fpsa_pkg::DATA_W-1:0] << PAGE_BITS;

   fpsa_ram #(
      .WIDTH (PN_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (pn_ext[PN_W-1:0]),
      .rd_en   (cmd.pop_read),
      .rd_addr (count_dec[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // output register: hold the beat until taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (cmd.rsp_from_ram) begin
            rsp_addr_in   = ram_page_addr;
            rsp_status_in = fpsa_pkg::STATUS_OK;
         end else begin
            rsp_addr_in   = '0;
            rsp_status_in = exec_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### design/free_page_stack_allocator_unit.sv
// Timing: rsp_tvalid is registered. A free request, or an allocate on an empty
// stack, goes through the request latch and the check state; any other allocate
// also goes through the registered stack read. Flow: one request in flight;
// the next is taken once the result is loaded, which waits for a free output slot.
// Reset: free page count to zero, kernel_end and phys_top to their reset
// values; the page store keeps no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// free_page_stack_allocator_unit: LIFO physical page allocator
// Free requests are checked against alignment, kernel_end and phys_top and,
// if they pass and the stack is not full, pushed; allocate requests pop the most recently freed page.
// ----------------------------------------------------------------------------
module free_page_stack_allocator_unit #(
   parameter int PAGE_BITS   = fpsa_pkg::PAGE_BITS_DEF,
   parameter int STACK_DEPTH = fpsa_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_BITS   = fpsa_pkg::ADDR_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fpsa_pkg::DATA_W-1:0]      req_tdata,   // [31:0] page_addr
   input  logic                             req_tuser,   // [0] opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fpsa_pkg::DATA_W-1:0]      rsp_tdata,   // [31:0] alloc_addr
   output logic [fpsa_pkg::STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fpsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpsa_pkg::DATA_W-1:0]      csr_data
);

   fpsa_pkg::dp_cmd_type  cmd;
   fpsa_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   fpsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fpsa_datapath #(
      .PAGE_BITS   (PAGE_BITS),
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_opcode (req_tuser),
      .req_addr   (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_addr   (rsp_tdata),
      .rsp_status (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // one request in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // any status other than ok carries a zero address
   a_zero_addr_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != fpsa_pkg::STATUS_OK)) |-> (rsp_tdata == '0))
      else $error("nonzero address on a failed request");

   // returned addresses are page aligned
   a_page_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[PAGE_BITS-1:0] == '0))
      else $error("response address not page aligned");

   // push and stack read never happen together
   a_push_xor_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop_read))
      else $error("push and pop issued in the same cycle");

endmodule
